// ===== hw/rtl/cpl_pkg.sv =====
// Shared types, constants and saturating helpers for the closest-points datapath.
package cpl_pkg;

  localparam int WideW  = 48;   // internal Q32.16 word, magnitude below 2^47
  localparam int MagW   = 47;   // magnitude bits of an internal word
  localparam int FracW  = 16;   // fraction bits
  localparam int EpsW   = 16;   // tolerance register width
  localparam int CoordW = 32;   // port coordinate width
  localparam int QBits  = 47;   // quotient bits resolved by the divider

  typedef logic signed [WideW-1:0] wide_t;
  typedef wide_t [2:0] vec_t;

  typedef struct packed {
    wide_t v;
    logic  ov;
  } sat_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  localparam logic [MagW-1:0] MagMax   = '1;
  localparam wide_t           WMax     = {1'b0, MagMax};
  localparam logic [EpsW-1:0] EpsReset = 16'd7;

  // Magnitude of a signed word.
  function automatic logic [WideW-1:0] abs_w(input wide_t a);
    return a[WideW-1] ? -a : a;
  endfunction

  // Add and clamp to the internal range.
  function automatic sat_t add_sat(input wide_t a, input wide_t b);
    logic signed [WideW:0] s;
    sat_t r;
    s = (WideW+1)'(a) + (WideW+1)'(b);
    r.v  = s[WideW-1:0];
    r.ov = 1'b0;
    if (s > (WideW+1)'(WMax)) begin
      r.v  = WMax;
      r.ov = 1'b1;
    end else if (s < -(WideW+1)'(WMax)) begin
      r.v  = -WMax;
      r.ov = 1'b1;
    end
    return r;
  endfunction

  // Subtract and clamp to the internal range.
  function automatic sat_t sub_sat(input wide_t a, input wide_t b);
    logic signed [WideW:0] s;
    sat_t r;
    s = (WideW+1)'(a) - (WideW+1)'(b);
    r.v  = s[WideW-1:0];
    r.ov = 1'b0;
    if (s > (WideW+1)'(WMax)) begin
      r.v  = WMax;
      r.ov = 1'b1;
    end else if (s < -(WideW+1)'(WMax)) begin
      r.v  = -WMax;
      r.ov = 1'b1;
    end
    return r;
  endfunction

  // Sum three products with a clamp after each add.
  function automatic sat_t sum3(input wide_t p0, input wide_t p1, input wide_t p2);
    sat_t t;
    sat_t u;
    t = add_sat(p0, p1);
    u = add_sat(t.v, p2);
    u.ov = u.ov | t.ov;
    return u;
  endfunction

  // True when every component is below the tolerance.
  function automatic logic near_zero(input vec_t a, input logic [EpsW-1:0] eps);
    logic  nz;
    wide_t e;
    nz = 1'b1;
    for (int i = 0; i < 3; i++) begin
      e = a[i];
      if (abs_w(e) >= WideW'(eps)) nz = 1'b0;
    end
    return nz;
  endfunction

endpackage

// ===== hw/rtl/cpl_mul.sv =====
// Pipelined multi-lane Q32.16 multiplier with saturation, three register stages.
module cpl_mul #(
  parameter int Lanes = 3,
  parameter int SbW   = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  cpl_pkg::wide_t [Lanes-1:0]  a_i,
  input  cpl_pkg::wide_t [Lanes-1:0]  b_i,
  input  logic [SbW-1:0]              sb_i,
  output logic                        valid_o,
  output cpl_pkg::wide_t [Lanes-1:0]  p_o,
  output logic [Lanes-1:0]            ov_o,
  output logic [SbW-1:0]              sb_o
);
  import cpl_pkg::*;

  localparam int HalfW = 24;
  localparam int HiW   = MagW - HalfW;
  localparam int ProdW = 2 * MagW;
  localparam int ShW   = ProdW - FracW;

  logic [2*HiW-1:0]      hh_d [Lanes];
  logic [2*HiW-1:0]      hh_q [Lanes];
  logic [HiW+HalfW-1:0]  hl_d [Lanes];
  logic [HiW+HalfW-1:0]  hl_q [Lanes];
  logic [HiW+HalfW-1:0]  lh_d [Lanes];
  logic [HiW+HalfW-1:0]  lh_q [Lanes];
  logic [2*HalfW-1:0]    ll_d [Lanes];
  logic [2*HalfW-1:0]    ll_q [Lanes];
  logic [ProdW-1:0]      sum_d [Lanes];
  logic [ProdW-1:0]      sum_q [Lanes];
  logic [Lanes-1:0]      neg_d, neg1_q, neg2_q;
  wide_t [Lanes-1:0]     p_d, p_q;
  logic [Lanes-1:0]      ov_d, ov_q;
  logic [SbW-1:0]        sb1_q, sb2_q, sb3_q;
  logic                  v1_q, v2_q, v3_q;

  // Split magnitudes into halves and form partial products.
  always_comb begin
    logic [WideW-1:0] ta;
    logic [WideW-1:0] tb;
    for (int l = 0; l < Lanes; l++) begin
      ta = abs_w(a_i[l]);
      tb = abs_w(b_i[l]);
      neg_d[l] = a_i[l][WideW-1] ^ b_i[l][WideW-1];
      hh_d[l] = (2*HiW)'(ta[MagW-1:HalfW]) * (2*HiW)'(tb[MagW-1:HalfW]);
      hl_d[l] = (HiW+HalfW)'(ta[MagW-1:HalfW]) * (HiW+HalfW)'(tb[HalfW-1:0]);
      lh_d[l] = (HiW+HalfW)'(ta[HalfW-1:0]) * (HiW+HalfW)'(tb[MagW-1:HalfW]);
      ll_d[l] = (2*HalfW)'(ta[HalfW-1:0]) * (2*HalfW)'(tb[HalfW-1:0]);
    end
  end

  // Combine partial products.
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      sum_d[l] = {hh_q[l], {(2*HalfW){1'b0}}}
               + (ProdW'(hl_q[l]) << HalfW)
               + (ProdW'(lh_q[l]) << HalfW)
               + ProdW'(ll_q[l]);
    end
  end

  // Drop the fraction, clamp and restore the sign.
  always_comb begin
    logic [ShW-1:0]  r;
    logic [MagW-1:0] mag;
    for (int l = 0; l < Lanes; l++) begin
      r = sum_q[l][ProdW-1:FracW];
      ov_d[l] = r > ShW'(MagMax);
      mag = ov_d[l] ? MagMax : r[MagW-1:0];
      p_d[l] = neg2_q[l] ? -wide_t'({1'b0, mag}) : wide_t'({1'b0, mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q   <= hh_d;
      hl_q   <= hl_d;
      lh_q   <= lh_d;
      ll_q   <= ll_d;
      neg1_q <= neg_d;
      sb1_q  <= sb_i;
      sum_q  <= sum_d;
      neg2_q <= neg1_q;
      sb2_q  <= sb1_q;
      p_q    <= p_d;
      ov_q   <= ov_d;
      sb3_q  <= sb2_q;
    end
  end

  assign valid_o = v3_q;
  assign p_o     = p_q;
  assign ov_o    = ov_q;
  assign sb_o    = sb3_q;

endmodule

// ===== hw/rtl/cpl_div.sv =====
// Pipelined Q32.16 divider, one restoring quotient bit per stage.
module cpl_div #(
  parameter int SbW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cpl_pkg::wide_t  a_i,
  input  cpl_pkg::wide_t  b_i,
  input  logic [SbW-1:0]  sb_i,
  output logic            valid_o,
  output cpl_pkg::wide_t  q_o,
  output logic            ov_o,
  output logic [SbW-1:0]  sb_o
);
  import cpl_pkg::*;

  typedef struct packed {
    logic [MagW-1:0] rem;
    logic [MagW-1:0] dvd;
    logic [MagW-1:0] quo;
    logic [MagW-1:0] ub;
    logic            neg;
    logic            zero;
    logic            sat;
    logic [SbW-1:0]  sb;
  } step_t;

  step_t          st_q  [QBits+1];
  logic           vld_q [QBits+1];
  step_t          st0_d;
  wide_t          q_d, q_q;
  logic           ov_q;
  logic           vout_q;
  logic [SbW-1:0] sbo_q;

  // Set up magnitudes; a quotient beyond the range is caught here.
  always_comb begin
    logic [WideW-1:0] ua;
    logic [WideW-1:0] ub;
    ua = abs_w(a_i);
    ub = abs_w(b_i);
    st0_d.rem  = MagW'(ua[MagW-1 -: FracW]);
    st0_d.dvd  = {ua[MagW-FracW-1:0], {FracW{1'b0}}};
    st0_d.quo  = '0;
    st0_d.ub   = ub[MagW-1:0];
    st0_d.neg  = a_i[WideW-1] ^ b_i[WideW-1];
    st0_d.zero = (ub[MagW-1:0] == '0);
    st0_d.sat  = (ub[MagW-1:0] != '0) && (MagW'(ua[MagW-1 -: FracW]) >= ub[MagW-1:0]);
    st0_d.sb   = sb_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (en_i) vld_q[0] <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q[0] <= st0_d;
  end

  // One shift, compare and subtract per stage.
  for (genvar k = 0; k < QBits; k++) begin : g_step
    logic [MagW:0] trial;
    logic          ge;
    step_t         nx;

    always_comb begin
      nx    = st_q[k];
      trial = {st_q[k].rem, st_q[k].dvd[MagW-1]};
      ge    = trial >= {1'b0, st_q[k].ub};
      nx.rem = ge ? MagW'(trial - {1'b0, st_q[k].ub}) : trial[MagW-1:0];
      nx.dvd = {st_q[k].dvd[MagW-2:0], 1'b0};
      nx.quo = {st_q[k].quo[MagW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else if (en_i) vld_q[k+1] <= vld_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) st_q[k+1] <= nx;
    end
  end

  // Resolve zero divisor and overflow, then apply the sign.
  always_comb begin
    wide_t mag;
    if (st_q[QBits].zero) mag = '0;
    else if (st_q[QBits].sat) mag = WMax;
    else mag = {1'b0, st_q[QBits].quo};
    q_d = st_q[QBits].neg ? -mag : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vout_q <= 1'b0;
    else if (en_i) vout_q <= vld_q[QBits];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q   <= q_d;
      ov_q  <= st_q[QBits].sat & ~st_q[QBits].zero;
      sbo_q <= st_q[QBits].sb;
    end
  end

  assign valid_o = vout_q;
  assign q_o     = q_q;
  assign ov_o    = ov_q;
  assign sb_o    = sbo_q;

endmodule

// ===== hw/rtl/closest_points_of_two_lines.sv =====
// Top level: closest points between two 3D lines, fully pipelined Q32.16 datapath.
//
// Slave stream s_axis carries one line pair per beat: four points (line one a, b;
// line two a, b), each x, y, z as signed Q16.16. Master stream m_axis returns one
// beat per input beat: near1 x, y, z and near2 x, y, z in tdata, status in tuser
// (0 ok, 1 parallel or degenerate, 2 saturated). Results leave in input order.
// The tolerance eps is written through cfg_we_i / cfg_wdata_i; the user must write
// it only while the block idles, as the block itself does not enforce this.
//
// The pipeline is made of three 49-stage dividers (one quotient bit per step stage),
// the seven three-stage multiplier banks and the add/clamp stages. Throughput is
// one beat per cycle while the output side does not stall. The whole pipeline
// advances together: when the output register holds an unaccepted beat, every
// stage holds and s_axis_tready drops, so nothing is lost or repeated. Reset
// clears all valid bits and sets eps to 7.
module closest_points_of_two_lines (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // l1a x,y,z; l1b x,y,z; l2a x,y,z; l2b x,y,z, 32 bits each from bit 0
  input  logic [383:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // near1 x,y,z; near2 x,y,z, 32 bits each from bit 0
  output logic [191:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);
  import cpl_pkg::*;

  typedef struct packed {
    vec_t  l1a, l2b, d1, d2, ab, c, m, p, w, q, r, n1, n2;
    wide_t dd, num, den;
    logic  nz_d1, nz_d2, nz_ab, nz_c, nz_w, nz_r, degen, ov;
  } ctx_t;

  localparam int    CtxW     = $bits(ctx_t);
  localparam wide_t CoordMax = 48'sh0000_7FFF_FFFF;
  localparam wide_t CoordMin = -48'sh0000_8000_0000;

  logic [EpsW-1:0] eps_q;
  logic            adv;

  ctx_t c0_d, c0_q;
  ctx_t e1_d, e1_q, e2_d, e2_q, e3_d, e3_q, e4_d, e4_q, e5_d, e5_q;
  ctx_t e6_d, e6_q, e7_d, e7_q, e8_d, e8_q, e9_d, e9_q, e10_d, e10_q;
  logic v0_q, e1_vld_q, e2_vld_q, e3_vld_q, e4_vld_q, e5_vld_q;
  logic e6_vld_q, e7_vld_q, e8_vld_q, e9_vld_q, e10_vld_q;

  wide_t [8:0] ma_a, ma_b, ma_p;
  logic  [8:0] ma_ov;
  ctx_t        ma_ctx;
  logic        ma_vld;
  wide_t [5:0] mb_a, mb_b, mb_p;
  logic  [5:0] mb_ov;
  ctx_t        mb_ctx;
  logic        mb_vld;
  wide_t [2:0] mc_b, mc_p;
  logic  [2:0] mc_ov;
  ctx_t        mc_in, mc_ctx;
  logic        mc_vld;
  wide_t [2:0] md_p;
  logic  [2:0] md_ov;
  ctx_t        md_ctx;
  logic        md_vld;
  wide_t [2:0] me_b, me_p;
  logic  [2:0] me_ov;
  ctx_t        me_in, me_ctx;
  logic        me_vld;
  wide_t [5:0] mf_a, mf_b, mf_p;
  logic  [5:0] mf_ov;
  ctx_t        mf_ctx;
  logic        mf_vld;
  wide_t [2:0] mg_b, mg_p;
  logic  [2:0] mg_ov;
  ctx_t        mg_in, mg_ctx;
  logic        mg_vld;

  wide_t dv1_q, dv2_q, dv3_q;
  logic  dv1_ov, dv2_ov, dv3_ov, dv1_vld, dv2_vld, dv3_vld;
  ctx_t  dv1_ctx, dv2_ctx, dv3_ctx;

  logic [191:0] data_d, data_q;
  status_e      status_d, status_q;
  logic         out_vld_q;

  // Advance every stage when the output register is free or being taken.
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) eps_q <= EpsReset;
    else if (cfg_we_i) eps_q <= cfg_wdata_i;
  end

  // Unpack points, form directions and the cross-line offset.
  always_comb begin
    vec_t l1b, l2a;
    sat_t t;
    c0_d = '0;
    for (int i = 0; i < 3; i++) begin
      c0_d.l1a[i] = WideW'($signed(s_axis_tdata[CoordW*i +: CoordW]));
      l1b[i]      = WideW'($signed(s_axis_tdata[CoordW*(i+3) +: CoordW]));
      l2a[i]      = WideW'($signed(s_axis_tdata[CoordW*(i+6) +: CoordW]));
      c0_d.l2b[i] = WideW'($signed(s_axis_tdata[CoordW*(i+9) +: CoordW]));
    end
    for (int i = 0; i < 3; i++) begin
      t = sub_sat(c0_d.l1a[i], l1b[i]);
      c0_d.d1[i] = t.v;
      c0_d.ov    = c0_d.ov | t.ov;
      t = sub_sat(l2a[i], c0_d.l2b[i]);
      c0_d.d2[i] = t.v;
      c0_d.ov    = c0_d.ov | t.ov;
      t = sub_sat(c0_d.l1a[i], c0_d.l2b[i]);
      c0_d.ab[i] = t.v;
      c0_d.ov    = c0_d.ov | t.ov;
    end
    c0_d.nz_d1 = near_zero(c0_d.d1, eps_q);
    c0_d.nz_d2 = near_zero(c0_d.d2, eps_q);
    c0_d.nz_ab = near_zero(c0_d.ab, eps_q);
  end

  // Cross product terms and |d1|^2 terms.
  always_comb begin
    ma_a[0] = c0_q.d1[1]; ma_b[0] = c0_q.d2[2];
    ma_a[1] = c0_q.d2[1]; ma_b[1] = c0_q.d1[2];
    ma_a[2] = c0_q.d1[2]; ma_b[2] = c0_q.d2[0];
    ma_a[3] = c0_q.d2[2]; ma_b[3] = c0_q.d1[0];
    ma_a[4] = c0_q.d1[0]; ma_b[4] = c0_q.d2[1];
    ma_a[5] = c0_q.d2[0]; ma_b[5] = c0_q.d1[1];
    for (int i = 0; i < 3; i++) begin
      ma_a[6+i] = c0_q.d1[i];
      ma_b[6+i] = c0_q.d1[i];
    end
  end

  cpl_mul #(.Lanes(9), .SbW(CtxW)) u_mul_a (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v0_q), .a_i(ma_a), .b_i(ma_b), .sb_i(c0_q),
    .valid_o(ma_vld), .p_o(ma_p), .ov_o(ma_ov), .sb_o(ma_ctx)
  );

  // Finish c and d1.d1.
  always_comb begin
    sat_t t;
    e1_d = ma_ctx;
    e1_d.ov = e1_d.ov | (|ma_ov);
    for (int i = 0; i < 3; i++) begin
      t = sub_sat(ma_p[2*i], ma_p[2*i+1]);
      e1_d.c[i] = t.v;
      e1_d.ov   = e1_d.ov | t.ov;
    end
    t = sum3(ma_p[6], ma_p[7], ma_p[8]);
    e1_d.dd   = t.v;
    e1_d.ov   = e1_d.ov | t.ov;
    e1_d.nz_c = near_zero(e1_d.c, eps_q);
  end

  // c.c and ab.c terms.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mb_a[i]   = e1_q.c[i];  mb_b[i]   = e1_q.c[i];
      mb_a[3+i] = e1_q.ab[i]; mb_b[3+i] = e1_q.c[i];
    end
  end

  cpl_mul #(.Lanes(6), .SbW(CtxW)) u_mul_b (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(e1_vld_q), .a_i(mb_a), .b_i(mb_b), .sb_i(e1_q),
    .valid_o(mb_vld), .p_o(mb_p), .ov_o(mb_ov), .sb_o(mb_ctx)
  );

  // Sum dots, flag degenerate geometry, set up ab.c / c.c.
  always_comb begin
    sat_t tc, ta;
    e2_d = mb_ctx;
    tc = sum3(mb_p[0], mb_p[1], mb_p[2]);
    ta = sum3(mb_p[3], mb_p[4], mb_p[5]);
    e2_d.ov = e2_d.ov | tc.ov | (|mb_ov[2:0])
            | ((ta.ov | (|mb_ov[5:3])) & ~e2_d.nz_ab);
    e2_d.degen = e2_d.nz_d1 | e2_d.nz_d2 | e2_d.nz_c | (tc.v == '0) | (e2_d.dd == '0);
    e2_d.num = ta.v;
    e2_d.den = tc.v;
  end

  cpl_div #(.SbW(CtxW)) u_div_1 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(e2_vld_q), .a_i(e2_q.num), .b_i(e2_q.den),
    .sb_i(e2_q), .valid_o(dv1_vld), .q_o(dv1_q), .ov_o(dv1_ov), .sb_o(dv1_ctx)
  );

  // Scale c by the offset ratio.
  always_comb begin
    mc_in = dv1_ctx;
    mc_in.ov = dv1_ctx.ov | (dv1_ov & ~dv1_ctx.nz_ab);
    for (int i = 0; i < 3; i++) mc_b[i] = dv1_q;
  end

  cpl_mul #(.Lanes(3), .SbW(CtxW)) u_mul_c (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(dv1_vld), .a_i(mc_in.c), .b_i(mc_b), .sb_i(mc_in),
    .valid_o(mc_vld), .p_o(mc_p), .ov_o(mc_ov), .sb_o(mc_ctx)
  );

  // Offset m and shifted point p.
  always_comb begin
    sat_t t;
    e3_d = mc_ctx;
    e3_d.ov = e3_d.ov | ((|mc_ov) & ~e3_d.nz_ab);
    for (int i = 0; i < 3; i++) begin
      e3_d.m[i] = e3_d.nz_ab ? wide_t'('0) : mc_p[i];
      t = add_sat(e3_d.l2b[i], e3_d.m[i]);
      e3_d.p[i] = t.v;
      e3_d.ov   = e3_d.ov | t.ov;
    end
  end

  // w = p - l1a.
  always_comb begin
    sat_t t;
    e4_d = e3_q;
    for (int i = 0; i < 3; i++) begin
      t = sub_sat(e3_q.p[i], e3_q.l1a[i]);
      e4_d.w[i] = t.v;
      e4_d.ov   = e4_d.ov | t.ov;
    end
    e4_d.nz_w = near_zero(e4_d.w, eps_q);
  end

  cpl_mul #(.Lanes(3), .SbW(CtxW)) u_mul_d (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(e4_vld_q), .a_i(e4_q.w), .b_i(e4_q.d1),
    .sb_i(e4_q), .valid_o(md_vld), .p_o(md_p), .ov_o(md_ov), .sb_o(md_ctx)
  );

  // Set up w.d1 / d1.d1.
  always_comb begin
    sat_t t;
    e5_d = md_ctx;
    t = sum3(md_p[0], md_p[1], md_p[2]);
    e5_d.ov  = e5_d.ov | ((t.ov | (|md_ov)) & ~e5_d.nz_w);
    e5_d.num = t.v;
    e5_d.den = e5_d.dd;
  end

  cpl_div #(.SbW(CtxW)) u_div_2 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(e5_vld_q), .a_i(e5_q.num), .b_i(e5_q.den),
    .sb_i(e5_q), .valid_o(dv2_vld), .q_o(dv2_q), .ov_o(dv2_ov), .sb_o(dv2_ctx)
  );

  // Scale d1 by the projection ratio.
  always_comb begin
    me_in = dv2_ctx;
    me_in.ov = dv2_ctx.ov | (dv2_ov & ~dv2_ctx.nz_w);
    for (int i = 0; i < 3; i++) me_b[i] = dv2_q;
  end

  cpl_mul #(.Lanes(3), .SbW(CtxW)) u_mul_e (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(dv2_vld), .a_i(me_in.d1), .b_i(me_b), .sb_i(me_in),
    .valid_o(me_vld), .p_o(me_p), .ov_o(me_ov), .sb_o(me_ctx)
  );

  // Projection q on line one.
  always_comb begin
    sat_t t;
    e6_d = me_ctx;
    e6_d.ov = e6_d.ov | ((|me_ov) & ~e6_d.nz_w);
    for (int i = 0; i < 3; i++) begin
      t = add_sat(e6_d.l1a[i], me_p[i]);
      e6_d.q[i] = e6_d.nz_w ? e6_d.l1a[i] : t.v;
      e6_d.ov   = e6_d.ov | (t.ov & ~e6_d.nz_w);
    end
  end

  // r = q - p.
  always_comb begin
    sat_t t;
    e7_d = e6_q;
    for (int i = 0; i < 3; i++) begin
      t = sub_sat(e6_q.q[i], e6_q.p[i]);
      e7_d.r[i] = t.v;
      e7_d.ov   = e7_d.ov | t.ov;
    end
    e7_d.nz_r = near_zero(e7_d.r, eps_q);
  end

  // r.r and r.d2 terms.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mf_a[i]   = e7_q.r[i]; mf_b[i]   = e7_q.r[i];
      mf_a[3+i] = e7_q.r[i]; mf_b[3+i] = e7_q.d2[i];
    end
  end

  cpl_mul #(.Lanes(6), .SbW(CtxW)) u_mul_f (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(e7_vld_q), .a_i(mf_a), .b_i(mf_b), .sb_i(e7_q),
    .valid_o(mf_vld), .p_o(mf_p), .ov_o(mf_ov), .sb_o(mf_ctx)
  );

  // Set up the walk ratio; an unwalkable offset is degenerate.
  always_comb begin
    sat_t tr, td;
    e8_d = mf_ctx;
    tr = sum3(mf_p[0], mf_p[1], mf_p[2]);
    td = sum3(mf_p[3], mf_p[4], mf_p[5]);
    e8_d.ov    = e8_d.ov | ((tr.ov | td.ov | (|mf_ov)) & ~e8_d.nz_r);
    e8_d.degen = e8_d.degen | (~e8_d.nz_r & (td.v == '0));
    e8_d.num   = tr.v;
    e8_d.den   = td.v;
  end

  cpl_div #(.SbW(CtxW)) u_div_3 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(e8_vld_q), .a_i(e8_q.num), .b_i(e8_q.den),
    .sb_i(e8_q), .valid_o(dv3_vld), .q_o(dv3_q), .ov_o(dv3_ov), .sb_o(dv3_ctx)
  );

  // Scale d2 by the walk ratio.
  always_comb begin
    mg_in = dv3_ctx;
    mg_in.ov = dv3_ctx.ov | (dv3_ov & ~dv3_ctx.nz_r);
    for (int i = 0; i < 3; i++) mg_b[i] = dv3_q;
  end

  cpl_mul #(.Lanes(3), .SbW(CtxW)) u_mul_g (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(dv3_vld), .a_i(mg_in.d2), .b_i(mg_b), .sb_i(mg_in),
    .valid_o(mg_vld), .p_o(mg_p), .ov_o(mg_ov), .sb_o(mg_ctx)
  );

  // Closest point on line two.
  always_comb begin
    sat_t t;
    e9_d = mg_ctx;
    e9_d.ov = e9_d.ov | ((|mg_ov) & ~e9_d.nz_r);
    for (int i = 0; i < 3; i++) begin
      t = add_sat(e9_d.l2b[i], mg_p[i]);
      e9_d.n2[i] = e9_d.nz_r ? e9_d.l2b[i] : t.v;
      e9_d.ov    = e9_d.ov | (t.ov & ~e9_d.nz_r);
    end
  end

  // Closest point on line one.
  always_comb begin
    sat_t t;
    e10_d = e9_q;
    for (int i = 0; i < 3; i++) begin
      t = add_sat(e9_q.n2[i], e9_q.m[i]);
      e10_d.n1[i] = t.v;
      e10_d.ov    = e10_d.ov | t.ov;
    end
  end

  // Clamp to port width and pick the status.
  always_comb begin
    wide_t v;
    logic  ov;
    ov = e10_q.ov;
    data_d = '0;
    for (int i = 0; i < 6; i++) begin
      v = (i < 3) ? e10_q.n1[i % 3] : e10_q.n2[i % 3];
      if (v > CoordMax) begin
        v  = CoordMax;
        ov = 1'b1;
      end else if (v < CoordMin) begin
        v  = CoordMin;
        ov = 1'b1;
      end
      data_d[CoordW*i +: CoordW] = v[CoordW-1:0];
    end
    if (e10_q.degen) begin
      data_d   = '0;
      status_d = ST_DEGEN;
    end else if (ov) begin
      status_d = ST_SAT;
    end else begin
      status_d = ST_OK;
    end
  end

  // Valid bits for the stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      e1_vld_q  <= 1'b0;
      e2_vld_q  <= 1'b0;
      e3_vld_q  <= 1'b0;
      e4_vld_q  <= 1'b0;
      e5_vld_q  <= 1'b0;
      e6_vld_q  <= 1'b0;
      e7_vld_q  <= 1'b0;
      e8_vld_q  <= 1'b0;
      e9_vld_q  <= 1'b0;
      e10_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v0_q      <= s_axis_tvalid;
      e1_vld_q  <= ma_vld;
      e2_vld_q  <= mb_vld;
      e3_vld_q  <= mc_vld;
      e4_vld_q  <= e3_vld_q;
      e5_vld_q  <= md_vld;
      e6_vld_q  <= me_vld;
      e7_vld_q  <= e6_vld_q;
      e8_vld_q  <= mf_vld;
      e9_vld_q  <= mg_vld;
      e10_vld_q <= e9_vld_q;
      out_vld_q <= e10_vld_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c0_q     <= c0_d;
      e1_q     <= e1_d;
      e2_q     <= e2_d;
      e3_q     <= e3_d;
      e4_q     <= e4_d;
      e5_q     <= e5_d;
      e6_q     <= e6_d;
      e7_q     <= e7_d;
      e8_q     <= e8_d;
      e9_q     <= e9_d;
      e10_q    <= e10_d;
      data_q   <= data_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = status_q;

  // The input side is open whenever the output register is empty.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  // An accepted input beat lands in the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v0_q)
    else $error("accepted beat missing from the first stage");

  // Degenerate results carry zero coordinates.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_DEGEN) |-> (m_axis_tdata == '0))
    else $error("degenerate result with nonzero coordinates");

endmodule

// ===== dv/cpl_checker.sv =====
// Checker for the closest-points block: predicts each result and compares it beat by beat.
`timescale 1ns / 1ps
module cpl_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [383:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [191:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int           fail_count_o,
  output int           pending_o
);
  import cpl_pkg::*;

  typedef logic signed [63:0] q_t;
  typedef q_t pt_t [3];

  typedef struct {
    logic [191:0] coords;
    logic [1:0]   status;
  } near_pts_t;

  localparam q_t QMax = 64'h0000_7FFF_FFFF_FFFF;

  near_pts_t       near_q[$];
  logic [15:0]     tol;
  bit              sat;

  // Clamp a value into the internal word range.
  function automatic q_t clip(input q_t x);
    if (x > QMax) begin sat = 1; return QMax; end
    if (x < -QMax) begin sat = 1; return -QMax; end
    return x;
  endfunction

  function automatic logic [63:0] mag(input q_t a);
    return a < 0 ? -a : a;
  endfunction

  // Q32.16 product, magnitude truncated.
  function automatic q_t qmul(input q_t a, input q_t b);
    logic [127:0] p;
    logic [63:0]  r;
    bit           neg;
    neg = (a < 0) != (b < 0);
    p = mag(a) * mag(b);
    r = p[79:16];
    if (p[127:80] != 0 || r > QMax) begin r = QMax; sat = 1; end
    return neg ? -q_t'(r) : q_t'(r);
  endfunction

  // Q32.16 quotient, magnitude truncated; zero divisor yields zero.
  function automatic q_t qdiv(input q_t a, input q_t b);
    logic [127:0] n;
    logic [127:0] r;
    bit           neg;
    neg = (a < 0) != (b < 0);
    if (b == 0) return 0;
    n = {64'd0, mag(a)} << 16;
    r = n / mag(b);
    if (r > QMax) begin r = QMax; sat = 1; end
    return neg ? -q_t'(r[63:0]) : q_t'(r[63:0]);
  endfunction

  function automatic pt_t psub(input pt_t a, input pt_t b);
    pt_t r;
    for (int i = 0; i < 3; i++) r[i] = clip(a[i] - b[i]);
    return r;
  endfunction

  function automatic pt_t padd(input pt_t a, input pt_t b);
    pt_t r;
    for (int i = 0; i < 3; i++) r[i] = clip(a[i] + b[i]);
    return r;
  endfunction

  function automatic pt_t pscale(input pt_t a, input q_t k);
    pt_t r;
    for (int i = 0; i < 3; i++) r[i] = qmul(a[i], k);
    return r;
  endfunction

  function automatic q_t pdot(input pt_t a, input pt_t b);
    q_t s;
    s = qmul(a[0], b[0]);
    s = clip(s + qmul(a[1], b[1]));
    return clip(s + qmul(a[2], b[2]));
  endfunction

  function automatic pt_t pcross(input pt_t a, input pt_t b);
    pt_t r;
    r[0] = clip(qmul(a[1], b[2]) - qmul(b[1], a[2]));
    r[1] = clip(qmul(a[2], b[0]) - qmul(b[2], a[0]));
    r[2] = clip(qmul(a[0], b[1]) - qmul(b[0], a[1]));
    return r;
  endfunction

  function automatic bit tiny(input pt_t a);
    for (int i = 0; i < 3; i++) if (mag(a[i]) >= tol) return 0;
    return 1;
  endfunction

  // Work out the closest points for one line pair.
  function automatic near_pts_t solve_pair(input logic [383:0] d);
    pt_t        pts [4];
    pt_t        d1, d2, ab, c, m, p, w, q, r, n1, n2;
    q_t         cc, dd, den, v;
    logic [1:0] st;
    near_pts_t  res;
    sat = 0;
    st = ST_OK;
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < 3; i++) pts[k][i] = q_t'($signed(d[(k*3+i)*32 +: 32]));
    d1 = psub(pts[0], pts[1]);
    d2 = psub(pts[2], pts[3]);
    ab = psub(pts[0], pts[3]);
    for (int i = 0; i < 3; i++) m[i] = 0;
    c = pcross(d1, d2);
    cc = pdot(c, c);
    dd = pdot(d1, d1);
    res.coords = '0;
    if (tiny(d1) || tiny(d2) || tiny(c) || cc == 0 || dd == 0) begin
      st = ST_DEGEN;
    end else begin
      if (!tiny(ab)) m = pscale(c, qdiv(pdot(ab, c), cc));
      p = padd(pts[3], m);
      w = psub(p, pts[0]);
      q = pts[0];
      if (!tiny(w)) q = padd(pts[0], pscale(d1, qdiv(pdot(w, d1), dd)));
      r = psub(q, p);
      n2 = pts[3];
      if (!tiny(r)) begin
        den = pdot(r, d2);
        if (den == 0) st = ST_DEGEN;
        else n2 = padd(pts[3], pscale(d2, qdiv(pdot(r, r), den)));
      end
      n1 = padd(n2, m);
      if (st != ST_DEGEN) begin
        for (int i = 0; i < 6; i++) begin
          v = i < 3 ? n1[i] : n2[i-3];
          if (v > 64'sd2147483647) begin v = 64'sd2147483647; sat = 1; end
          if (v < -64'sd2147483648) begin v = -64'sd2147483648; sat = 1; end
          res.coords[i*32 +: 32] = v[31:0];
        end
        st = sat ? ST_SAT : ST_OK;
      end
    end
    res.status = st;
    return res;
  endfunction

  assign pending_o = near_q.size();

  // Track the tolerance, queue predictions, compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    near_pts_t exp_pts;
    if (!rst_ni) begin
      tol <= EpsReset;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) tol <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) near_q.push_back(solve_pair(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (near_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result beat %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_pts = near_q.pop_front();
          if (exp_pts.coords !== m_axis_tdata || exp_pts.status !== m_axis_tuser) begin
            if (fail_count_o < 10)
              $display("mismatch: exp %h st %0d, got %h st %0d", exp_pts.coords,
                       exp_pts.status, m_axis_tdata, m_axis_tuser);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: drives line pairs and tolerance settings, reports the verdict.
`timescale 1ns / 1ps
module tb_top;
  import cpl_pkg::*;

  localparam int Latency = 180;
  localparam int CycleCap = 400000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [15:0]  cfg_wdata_i = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [383:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [191:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  int           fail_count;
  int           pending;
  int           cycles = 0;
  int           src_idle = 24;
  int           snk_idle = 58;

  closest_points_of_two_lines u_dut (.*);

  cpl_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .s_axis_tvalid, .s_axis_tready,
    .s_axis_tdata, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Randomly stall the result side; abort on the cycle cap.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    m_axis_tready <= ($urandom_range(99) >= snk_idle);
    if (cycles > CycleCap) begin
      $display("closest_points_of_two_lines test failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000 | $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return $urandom();
      3: return 32'($signed($urandom_range(64)) - 32);
      default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
    endcase
  endfunction

  // Build a pair: random, shared point, parallel, degenerate or tiny offsets.
  function automatic logic [383:0] rand_pair();
    logic [383:0] d;
    int           kind;
    for (int i = 0; i < 12; i++) d[i*32 +: 32] = rand_coord();
    kind = $urandom_range(9);
    if (kind == 0) d[383:288] = d[95:0];
    if (kind == 1) d[191:96] = d[95:0];
    if (kind == 2) for (int i = 0; i < 3; i++)
      d[(9+i)*32 +: 32] = d[(6+i)*32 +: 32] + d[(3+i)*32 +: 32] - d[i*32 +: 32];
    if (kind == 3) for (int i = 0; i < 3; i++)
      d[(3+i)*32 +: 32] = d[i*32 +: 32] + 32'($urandom_range(8));
    return d;
  endfunction

  // Idle, then present one beat and hold it until accepted.
  task automatic send_pair(input logic [383:0] d);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tdata <= d;
    s_axis_tvalid <= 1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
  endtask

  task automatic set_tol(input logic [15:0] v);
    cfg_wdata_i <= v;
    cfg_we_i <= 1;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [383:0] d;
    logic [15:0]  tols [4];
    tols = '{16'd0, 16'hFFFF, 16'd7, 16'd300};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, degenerate pairs, a crossing, a skew pair and a near crossing.
    send_pair('0);
    send_pair('1);
    send_pair({12{32'h8000_0000}});
    send_pair({12{32'h7FFF_FFFF}});
    for (int k = 0; k < 12; k++) begin
      d = '0;
      d[k*32 +: 32] = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      send_pair(d);
    end
    send_pair({32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0, 32'hFFFF_0000,
               32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0});
    send_pair({32'h2_0000, 32'h0, 32'h1_0000, 32'h2_0000, 32'h0, 32'hFFFF_0000,
               32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0});
    send_pair({32'h1, 32'h0, 32'h1_0000, 32'h0, 32'h3, 32'hFFFF_0000,
               32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h2});
    drain();

    // Random phases over tolerance settings: receiver stalls most, then sender, then neither.
    for (int ph = 0; ph < 12; ph++) begin
      src_idle = (ph / 4 == 0) ? 24 : (ph / 4 == 1) ? 58 : 0;
      snk_idle = (ph / 4 == 0) ? 58 : (ph / 4 == 1) ? 24 : 0;
      set_tol(ph < 4 ? tols[ph] : 16'($urandom()));
      repeat (50) send_pair(rand_pair());
      drain();
    end

    if (fail_count == 0) begin
      $display("closest_points_of_two_lines test passed");
    end else begin
      $display("closest_points_of_two_lines test failed");
    end
    $finish;
  end

endmodule
